// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the coalescent transition-probability RTL.
// Included by the files that check their own logic; depends on nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// The property must hold at every rising edge outside reset.
`define ASSERT_AT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");

// The condition must never be seen at a rising edge outside reset.
`define ASSERT_NEVER(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("forbidden condition seen");

`else

`define ASSERT_AT(label, clk, rst, prop)
`define ASSERT_NEVER(label, clk, rst, cond)

`endif

`endif

// ===== rtl/core/ctp_pkg.sv =====
// Package for the coalescent transition-probability unit: codes, state type,
// table address type and the saturation limit. Depends on nothing.
package ctp_pkg;

  localparam int DATA_W  = 32;
  localparam int IDX_FW  = 6;
  localparam int ROW_W   = 3;
  localparam int ACC_W   = DATA_W + 7;

  typedef enum logic {
    ACT_LOAD  = 1'b0,
    ACT_QUERY = 1'b1
  } action_t;

  localparam logic [ROW_W-1:0] ROW_P1 = 3'd1;
  localparam logic [ROW_W-1:0] ROW_P2 = 3'd2;
  localparam logic [ROW_W-1:0] ROW_P3 = 3'd3;
  localparam logic [ROW_W-1:0] ROW_P4 = 3'd4;
  localparam logic [ROW_W-1:0] ROW_P5 = 3'd5;
  localparam logic [ROW_W-1:0] ROW_P6 = 3'd6;
  localparam logic [ROW_W-1:0] ROW_P7 = 3'd7;

  typedef struct packed {
    logic [ROW_W-1:0]  row;
    logic [IDX_FW-1:0] idx;
  } tab_addr_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_START,
    S_BASE,
    S_BASE_ADD,
    S_BASE_ADD2,
    S_NEXT,
    S_MUL_HP,
    S_CHAIN,
    S_FINAL,
    S_ACC,
    S_DONE
  } seq_state_t;

  // Largest total that fits the result: one, or all ones if one is wider.
  function automatic logic [DATA_W-1:0] cap_of(input int frac_bits);
    logic [63:0] one;
    one = 64'd1 << frac_bits;
    if (frac_bits >= DATA_W) begin
      return {DATA_W{1'b1}};
    end
    return one[DATA_W-1:0];
  endfunction

endpackage

// ===== rtl/core/ctp_mem.sv =====
// Probability table of seven rows by NUM_INTERVALS entries, one write and one
// registered read port. Depends on ctp_pkg.
module ctp_mem
  import ctp_pkg::*;
#(
  parameter int NUM_INTERVALS = 64
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ROW_W-1:0]  wr_row,
  input  logic [IDX_FW-1:0] wr_slot,
  input  logic [DATA_W-1:0] wr_data,
  input  tab_addr_t         rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  localparam int IDX_W     = $clog2(NUM_INTERVALS);
  localparam int XW        = (IDX_W > IDX_FW) ? IDX_W : IDX_FW;
  localparam int AW        = ROW_W + IDX_W;
  localparam int MEM_DEPTH = 7 * (1 << IDX_W);

  logic [DATA_W-1:0] mem [MEM_DEPTH];
  logic [DATA_W-1:0] mem_q;
  logic              rd_zero;

  logic [XW-1:0] wr_ext;
  logic [XW-1:0] rd_ext;
  logic          wr_ok;
  logic          rd_ok;
  logic [AW-1:0] wr_a;
  logic [AW-1:0] rd_a;

  always_comb begin
    wr_ext = XW'(wr_slot);
    rd_ext = XW'(rd_addr.idx);
    wr_ok  = (wr_row != '0) && (int'(wr_slot) < NUM_INTERVALS);
    rd_ok  = (rd_addr.row != '0) && (int'(rd_addr.idx) < NUM_INTERVALS);
    wr_a   = {3'(wr_row - 3'd1), wr_ext[IDX_W-1:0]};
    rd_a   = {3'(rd_addr.row - 3'd1), rd_ext[IDX_W-1:0]};
  end

  always_ff @(posedge clk) begin
    if (wr_en && wr_ok) begin
      mem[wr_a] <= wr_data;
    end
  end

  // Entries outside the table read as zero.
  always_ff @(posedge clk) begin
    mem_q   <= mem[rd_a];
    rd_zero <= !rd_ok;
  end

  assign rd_data = rd_zero ? '0 : mem_q;

endmodule

// ===== rtl/core/ctp_mul.sv =====
// Shared fixed-point multiplier: registered 32x32 product, truncated by
// FRAC_BITS on the way out. Depends on ctp_pkg.
module ctp_mul
  import ctp_pkg::*;
#(
  parameter int FRAC_BITS = 31
) (
  input  logic              clk,
  input  logic [DATA_W-1:0] a,
  input  logic [DATA_W-1:0] b,
  output logic [DATA_W-1:0] res
);

  logic [2*DATA_W-1:0] prod;

  always_ff @(posedge clk) begin
    prod <= (2*DATA_W)'(a) * (2*DATA_W)'(b);
  end

  // Operands never exceed the cap, so the truncated product fits the word.
  assign res = DATA_W'(prod >> FRAC_BITS);

endmodule

// ===== rtl/core/ctp_seq.sv =====
// Query sequencer: walks the chain terms of one query through the shared
// multiplier and table port and accumulates the total. Depends on ctp_pkg.
`include "assert_macros.svh"

module ctp_seq
  import ctp_pkg::*;
#(
  parameter int FRAC_BITS = 31
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [IDX_FW-1:0] k_in,
  input  logic [IDX_FW-1:0] j_in,
  output logic              ready,
  output tab_addr_t         rd_addr,
  input  logic [DATA_W-1:0] rd_data,
  output logic [DATA_W-1:0] mul_a,
  output logic [DATA_W-1:0] mul_b,
  input  logic [DATA_W-1:0] mul_res,
  input  logic              out_free,
  output logic              res_valid,
  output logic [DATA_W-1:0] res_prob,
  output logic              res_sat
);

  localparam logic [DATA_W-1:0] CAP = cap_of(FRAC_BITS);

  seq_state_t state, state_next;

  logic [IDX_FW-1:0] k, k_next;
  logic [IDX_FW-1:0] j, j_next;
  logic [IDX_FW-1:0] i, i_next;
  logic [IDX_FW-1:0] from, from_next;
  logic [IDX_FW-1:0] l, l_next;
  logic [DATA_W-1:0] p2, p2_next;
  logic [DATA_W-1:0] hreg, hreg_next;
  logic [ACC_W-1:0]  acc, acc_next;
  logic              first, first_next;
  logic              empty, empty_next;

  logic [IDX_FW-1:0] lim;
  logic [IDX_FW:0]   from_inc;
  logic [IDX_FW:0]   l_inc;
  logic              over;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    k     <= k_next;
    j     <= j_next;
    i     <= i_next;
    from  <= from_next;
    l     <= l_next;
    p2    <= p2_next;
    hreg  <= hreg_next;
    acc   <= acc_next;
    first <= first_next;
    empty <= empty_next;
  end

  always_comb begin
    lim      = (k < j) ? k : j;
    from_inc = {1'b0, from} + 7'd1;
    l_inc    = {1'b0, l} + 7'd1;
    over     = acc > ACC_W'(CAP);
    res_prob = over ? CAP : acc[DATA_W-1:0];
    res_sat  = over;
  end

  always_comb begin
    state_next = state;
    k_next     = k;
    j_next     = j;
    i_next     = i;
    from_next  = from;
    l_next     = l;
    p2_next    = p2;
    hreg_next  = hreg;
    acc_next   = acc;
    first_next = first;
    empty_next = empty;
    ready      = 1'b0;
    res_valid  = 1'b0;
    rd_addr    = '{row: ROW_P5, idx: l_inc[IDX_FW-1:0]};
    mul_a      = CAP;
    mul_b      = rd_data;

    unique case (state)
      S_IDLE: begin
        ready = 1'b1;
        if (start) begin
          k_next     = k_in;
          j_next     = j_in;
          i_next     = '0;
          acc_next   = '0;
          state_next = S_START;
        end
      end
      S_START: begin
        rd_addr    = '{row: ROW_P2, idx: j};
        state_next = S_BASE;
      end
      S_BASE: begin
        p2_next = rd_data;
        if (k > j) begin
          rd_addr    = '{row: ROW_P3, idx: j};
          state_next = S_BASE_ADD;
        end else if (k == j) begin
          rd_addr    = '{row: ROW_P1, idx: k};
          state_next = S_BASE_ADD;
        end else begin
          rd_addr    = '{row: ROW_P6, idx: k};
          from_next  = k;
          state_next = S_MUL_HP;
        end
      end
      S_BASE_ADD: begin
        acc_next = ACC_W'(rd_data);
        if (k == j) begin
          rd_addr    = '{row: ROW_P4, idx: k};
          state_next = S_BASE_ADD2;
        end else begin
          state_next = S_NEXT;
        end
      end
      S_BASE_ADD2: begin
        acc_next   = acc + ACC_W'(rd_data);
        state_next = S_NEXT;
      end
      S_NEXT, S_ACC: begin
        if (state == S_ACC) begin
          acc_next = acc + ACC_W'(mul_res);
        end
        if (i < lim) begin
          rd_addr    = '{row: ROW_P7, idx: i};
          from_next  = i;
          i_next     = IDX_FW'(i + 6'd1);
          state_next = S_MUL_HP;
        end else begin
          state_next = S_DONE;
        end
      end
      S_MUL_HP: begin
        mul_a   = rd_data;
        mul_b   = p2;
        rd_addr = '{row: ROW_P5, idx: from_inc[IDX_FW-1:0]};
        l_next  = from_inc[IDX_FW-1:0];
        if (from_inc >= {1'b0, j}) begin
          empty_next = 1'b1;
          state_next = S_FINAL;
        end else begin
          empty_next = 1'b0;
          first_next = 1'b1;
          state_next = S_CHAIN;
        end
      end
      S_CHAIN: begin
        // The first pass keeps head times P2 and starts the product at one.
        mul_a      = first ? CAP : mul_res;
        mul_b      = rd_data;
        first_next = 1'b0;
        if (first) begin
          hreg_next = mul_res;
        end
        l_next = l_inc[IDX_FW-1:0];
        if (l_inc == {1'b0, j}) begin
          state_next = S_FINAL;
        end
      end
      S_FINAL: begin
        mul_a      = empty ? CAP : mul_res;
        mul_b      = empty ? mul_res : hreg;
        state_next = S_ACC;
      end
      S_DONE: begin
        if (out_free) begin
          res_valid  = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  `ASSERT_NEVER(a_chain_in_range, clk, rst, (state == S_CHAIN) && (l >= j))
  `ASSERT_AT(a_term_below_dest, clk, rst, (state == S_MUL_HP) |-> (from < j))
  `ASSERT_AT(a_terms_bounded, clk, rst, ((state == S_NEXT) || (state == S_ACC)) |-> (i <= lim))

endmodule

// ===== rtl/core/coalescent_transition_prob_unit.sv =====
// Top level of the coalescent transition-probability unit: stream ports,
// load path, result register. Depends on ctp_pkg, ctp_mem, ctp_mul, ctp_seq.
`include "assert_macros.svh"

// The unit keeps seven probability rows P1 to P7 of NUM_INTERVALS entries each
// in one table memory, and answers transition queries for a state pair (k, j)
// in unsigned fixed point with FRAC_BITS fraction bits (Q1.31 by default).
// A load word (tuser low) writes one entry; values above one are stored as
// one, and loads to row zero or to a slot beyond the table are dropped.
// A query word (tuser high) returns one result
// word: P6[k]*P2[j]*prod P5[k+1..j-1] when k is below j, P1[k]+P4[k] when
// they are equal and P3[j] when k is above j, plus the sum over i below
// min(k,j) of P7[i]*P2[j]*prod P5[i+1..j-1]. Every product is truncated and
// the total is clipped at one, with the saturated flag raised on clipping.
// All multiplications go through a single registered multiplier, and the
// table has a single read port, so a query is worked one multiply per cycle
// under a small sequencer, which works the base term first and then each
// chain term in turn, accumulating the total as it goes. The input is
// not ready while a query is in progress. The finished result sits in an
// output register, so the next word is taken while it waits to be read.
// Every table entry that a query touches must have been loaded before.
module coalescent_transition_prob_unit
  import ctp_pkg::*;
#(
  parameter int NUM_INTERVALS = 64,
  parameter int FRAC_BITS     = 31
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // row[2:0], slot[8:3], value[40:9], from_state[46:41], to_state[52:47]
  input  logic [55:0] s_tdata,
  // action[0]
  input  logic        s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // prob[31:0]
  output logic [31:0] m_tdata,
  // saturated[0]
  output logic        m_tuser
);

  localparam logic [63:0]       ONE = 64'd1 << FRAC_BITS;
  localparam logic [DATA_W-1:0] CAP = cap_of(FRAC_BITS);

  logic [ROW_W-1:0]  in_row;
  logic [IDX_FW-1:0] in_slot;
  logic [DATA_W-1:0] in_value;
  logic [IDX_FW-1:0] in_from;
  logic [IDX_FW-1:0] in_to;
  logic [DATA_W-1:0] value_sat;

  logic      accept;
  logic      load_go;
  logic      query_go;
  tab_addr_t rd_addr;
  logic [DATA_W-1:0] rd_data;
  logic [DATA_W-1:0] mul_a;
  logic [DATA_W-1:0] mul_b;
  logic [DATA_W-1:0] mul_res;
  logic              seq_ready;
  logic              out_free;
  logic              res_valid;
  logic [DATA_W-1:0] res_prob;
  logic              res_sat;

  // Unpack the input word.
  always_comb begin
    in_row    = s_tdata[2:0];
    in_slot   = s_tdata[8:3];
    in_value  = s_tdata[40:9];
    in_from   = s_tdata[46:41];
    in_to     = s_tdata[52:47];
    // A value above one is clipped to one on the way into the table.
    value_sat = ({32'd0, in_value} > ONE) ? ONE[DATA_W-1:0] : in_value;
  end

  assign s_tready = seq_ready;
  assign accept   = s_tvalid && s_tready;
  assign load_go  = accept && (s_tuser == ACT_LOAD);
  assign query_go = accept && (s_tuser == ACT_QUERY);
  assign out_free = !m_tvalid || m_tready;

  ctp_mem #(
    .NUM_INTERVALS(NUM_INTERVALS)
  ) u_mem (
    .clk     (clk),
    .wr_en   (load_go),
    .wr_row  (in_row),
    .wr_slot (in_slot),
    .wr_data (value_sat),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  ctp_mul #(
    .FRAC_BITS(FRAC_BITS)
  ) u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .res (mul_res)
  );

  ctp_seq #(
    .FRAC_BITS(FRAC_BITS)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .start     (query_go),
    .k_in      (in_from),
    .j_in      (in_to),
    .ready     (seq_ready),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .mul_a     (mul_a),
    .mul_b     (mul_b),
    .mul_res   (mul_res),
    .out_free  (out_free),
    .res_valid (res_valid),
    .res_prob  (res_prob),
    .res_sat   (res_sat)
  );

  // Result register: loaded only when empty or being read in the same cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_valid) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      m_tdata <= res_prob;
      m_tuser <= res_sat;
    end
  end

  `ASSERT_AT(a_sat_means_cap, clk, rst, (m_tvalid && m_tuser) |-> (m_tdata == CAP))
  `ASSERT_AT(a_query_busy, clk, rst, query_go |=> !s_tready)
  `ASSERT_NEVER(a_no_overwrite, clk, rst, res_valid && m_tvalid && !m_tready)

endmodule
